### design/htmb_pkg.sv
// Package for the hall tachometer and motor brake control block.
// Holds the request and result structs, divider status, and shared constants.
// No dependencies.
package htmb_pkg;

    // Field and datapath widths
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 17;
    localparam int RPM_W      = 16;
    localparam int SKIP_W     = 4;
    localparam int STOP_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = 5;

    // Divider runs one quotient bit per cycle over the whole dividend
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

    // Saturation limits
    localparam logic [RPM_W-1:0]  RPM_MAX  = 16'hFFFF;
    localparam logic [STOP_W-1:0] STOP_MAX = 8'hFF;

    // Reset values
    localparam logic [DIVIDEND_W-1:0] RPM_CONST_RESET  = 32'd1636350;
    localparam logic [STOP_W-1:0]     STOP_THR_RESET   = 8'd10;
    localparam logic [SKIP_W-1:0]     STARTUP_SKIP_DEF = 4'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_CONSTANT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOPPED_THRESHOLD = 1'd1;

    // Request modes
    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [15:0]        capture_value;
        logic               overflow_seen;
        logic               fault_flag;
        logic               shutdown_req;
        logic signed [15:0] duty_setpoint;
        logic [31:0]        previous_tacho;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] applied_duty;
        logic               run_enable;
        logic               brake_on;
        logic [31:0]        edge_count;
        logic [16:0]        period_ticks;
        logic [15:0]        speed_rpm;
        logic               safely_stopped;
    } t_out_res;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### design/htmb_div.sv
// Bit-serial restoring divider for the rpm computation, one quotient bit per cycle.
// The quotient is saturated to 16 bits. Depends on htmb_pkg.
module htmb_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [htmb_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [htmb_pkg::DIVISOR_W-1:0]   i_divisor,
    output htmb_pkg::t_div_stat              o_stat,
    output logic [htmb_pkg::RPM_W-1:0]       o_quot
);
    import htmb_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [DIVISOR_W:0]      r_rem;
    logic [DIVIDEND_W-1:0]   r_dvd;
    logic [DIVIDEND_W-1:0]   r_quo;
    logic [DIVISOR_W-1:0]    r_dsr;

    logic [DIVISOR_W:0]      rem_sh;
    logic                    q_bit;
    logic [DIVISOR_W:0]      rem_nx;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh = {r_rem[DIVISOR_W-1:0], r_dvd[DIVIDEND_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dsr});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
    end

    // Control: busy while stepping, done pulses once after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
            r_quo <= {r_quo[DIVIDEND_W-2:0], q_bit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = (|r_quo[DIVIDEND_W-1:RPM_W]) ? RPM_MAX : r_quo[RPM_W-1:0];

endmodule

### design/hall_tacho_and_motor_brake_control.sv
// Hall tachometer with motor run/brake control. A control tick request, and a
// capture request that needs no division, goes from acceptance to the emit state and
// then into the output register; a capture that needs a division first waits in the
// division state for the 32-step bit-serial divider. One request is in work at a time;
// the next is accepted when the sequencer is idle, even while the previous result still
// waits in the output register, but not while the previous request is in the sequencer.
// Synchronous active-low reset restores the control, tachometer and output valid state
module hall_tacho_and_motor_brake_control #(
    parameter logic [htmb_pkg::SKIP_W-1:0] STARTUP_SKIP = htmb_pkg::STARTUP_SKIP_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  htmb_pkg::t_in_req                 i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output htmb_pkg::t_out_res                o_out_res,
    input  logic                              i_cfg_we,
    input  logic [htmb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [htmb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import htmb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [DIVIDEND_W-1:0]  r_rpm_const;
    logic [STOP_W-1:0]      r_stop_thr;
    logic [SKIP_W-1:0]      r_skip, n_skip;
    logic [15:0]            r_last, n_last;
    logic [31:0]            r_edges, n_edges;
    logic [DIVISOR_W-1:0]   r_period, n_period;
    logic [RPM_W-1:0]       r_rpm, n_rpm;
    logic signed [15:0]     r_duty, n_duty;
    logic [STOP_W-1:0]      r_stopped, n_stopped;
    logic                   r_brake, n_brake;
    logic                   r_run, n_run;
    logic                   r_out_valid;
    t_out_res               r_out;

    logic                   accept;
    logic                   div_start;
    logic                   slot_free;
    logic signed [15:0]     duty_req;
    t_div_stat              div_stat;
    logic [RPM_W-1:0]       div_quot;

    assign accept    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    // Divider for rpm = constant / period, used by capture requests.
    htmb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rpm_const),
        .i_divisor  (n_period),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_const <= RPM_CONST_RESET;
            r_stop_thr  <= STOP_THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RPM_CONSTANT:      r_rpm_const <= i_cfg_data;
                CFG_STOPPED_THRESHOLD: r_stop_thr  <= i_cfg_data[STOP_W-1:0];
                default: ;
            endcase
        end
    end

    // Request processing and sequencer.
    always_comb begin
        n_state   = r_state;
        n_skip    = r_skip;
        n_last    = r_last;
        n_edges   = r_edges;
        n_period  = r_period;
        n_rpm     = r_rpm;
        n_duty    = r_duty;
        n_stopped = r_stopped;
        n_brake   = r_brake;
        n_run     = r_run;
        div_start = 1'b0;
        duty_req  = (i_in_req.fault_flag || i_in_req.shutdown_req) ? 16'sd0
                                                                   : i_in_req.duty_setpoint;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EMIT;
                    if (i_in_req.mode == MODE_CAPTURE) begin
                        n_last = i_in_req.capture_value;
                        if (r_skip != '0) begin
                            n_skip = r_skip - 1'b1;
                        end else begin
                            n_edges = r_edges + 32'd1;
                            if (i_in_req.overflow_seen) begin
                                n_period = {1'b0, i_in_req.capture_value} + 17'h10000
                                         - {1'b0, r_last};
                            end else begin
                                n_period = {1'b0, i_in_req.capture_value - r_last};
                            end
                            if (n_period == '0) begin
                                n_rpm = '0;
                            end else begin
                                div_start = 1'b1;
                                n_state   = ST_DIV;
                            end
                        end
                    end else begin
                        // Stopped detection runs only while zero duty is requested.
                        if (duty_req == 16'sd0) begin
                            if (r_edges == i_in_req.previous_tacho) begin
                                if (r_stopped > r_stop_thr) begin
                                    n_period = '0;
                                    n_rpm    = '0;
                                    n_brake  = 1'b0;
                                end else if (r_stopped < STOP_MAX) begin
                                    n_stopped = r_stopped + 1'b1;
                                end
                            end else begin
                                n_stopped = '0;
                            end
                        end
                        // A changed duty drives the run and brake lines.
                        if (duty_req != r_duty) begin
                            n_run     = (duty_req != 16'sd0);
                            n_brake   = (duty_req == 16'sd0);
                            n_duty    = duty_req;
                            n_stopped = '0;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_rpm   = div_quot;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_skip    <= STARTUP_SKIP;
            r_last    <= '0;
            r_edges   <= '0;
            r_period  <= '0;
            r_rpm     <= '0;
            r_duty    <= '0;
            r_stopped <= '0;
            r_brake   <= 1'b0;
            r_run     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_skip    <= n_skip;
            r_last    <= n_last;
            r_edges   <= n_edges;
            r_period  <= n_period;
            r_rpm     <= n_rpm;
            r_duty    <= n_duty;
            r_stopped <= n_stopped;
            r_brake   <= n_brake;
            r_run     <= n_run;
        end
    end

    // Output register: a snapshot of the state once the request is complete.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && slot_free) begin
            r_out.applied_duty   <= r_duty;
            r_out.run_enable     <= r_run;
            r_out.brake_on       <= r_brake;
            r_out.edge_count     <= r_edges;
            r_out.period_ticks   <= r_period;
            r_out.speed_rpm      <= r_rpm;
            r_out.safely_stopped <= (r_stopped > r_stop_thr);
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // The divider only works while the sequencer waits on it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.busy || div_stat.done) |-> (r_state == ST_DIV))
        else $error("divider active outside the division state");

    // A zero period always comes with a zero speed.
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_period == '0) |-> (r_rpm == '0))
        else $error("nonzero rpm with zero period");

    // Run and brake lines are never active together.
    a_run_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_brake))
        else $error("run and brake both active");

    // Stopped ticks accumulate only while the applied duty is zero.
    a_stopped_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped != '0) |-> (r_duty == 16'sd0))
        else $error("stopped count with nonzero duty");

endmodule
